[rtl/core/npcs_pkg.sv]
// Shared types and constants for the nearest palette color search block.
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

  localparam int CHAN_W        = 16;
  localparam int ENTRY_W       = 8;
  localparam int COLOR_W       = 3 * CHAN_W;
  localparam int DIST_W        = 18;
  localparam int DEFAULT_DEPTH = 256;

  localparam logic [DIST_W-1:0]  DIST_BOUND = DIST_W'(65535 * 3);
  localparam logic [ENTRY_W-1:0] LAST_RESET = ENTRY_W'(255);

  // Register indexes, counted in 32-bit words.
  localparam logic REG_LAST_ENTRY = 1'b0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic wr_en;
    logic start;
    logic issue;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/core/npcs_ctrl.sv]
// Controller state machine that sequences palette writes and query scans.
`timescale 1ns / 1ps
`default_nettype none

module npcs_ctrl
  import npcs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  input  wire op_t     opcode,
  output logic         s_tready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_QUERY) begin
            cmd.start  = 1'b1;
            state_next = S_SCAN;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !sts.pipe_busy)
    else $error("pipeline busy while accepting beats");

  a_scan_to_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && sts.scan_last) |=> (state == S_DRAIN))
    else $error("scan did not stop after last entry");

  a_result_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && sts.out_free) |=> (state == S_IDLE))
    else $error("result not handed off when output was free");
`endif

endmodule

`default_nettype wire

[rtl/core/npcs_datapath.sv]
// Palette memory, distance pipeline, best-match tracker and output register.
`timescale 1ns / 1ps
`default_nettype none

module npcs_datapath
  import npcs_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  output dp_sts_t                 sts,
  input  wire logic [ENTRY_W-1:0] entry_index,
  input  wire logic [CHAN_W-1:0]  red,
  input  wire logic [CHAN_W-1:0]  green,
  input  wire logic [CHAN_W-1:0]  blue,
  input  wire logic [ENTRY_W-1:0] last_entry,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [ENTRY_W-1:0]      match_index
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);

  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

  logic [IDX_W-1:0]   cnt;
  logic [IDX_W-1:0]   lim;
  logic               wr_ok;
  logic [CHAN_W-1:0]  q_r, q_g, q_b;

  logic               va, vb, vc;
  logic [IDX_W-1:0]   idx_a, idx_b, idx_c;
  logic [COLOR_W-1:0] rd_data;
  logic [CHAN_W-1:0]  d_r, d_g, d_b;
  logic [DIST_W-1:0]  sum_c;
  logic [CHAN_W-1:0]  p_r, p_g, p_b;

  logic [DIST_W-1:0]  best;
  logic [IDX_W-1:0]   pick;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign wr_ok = (32'(entry_index) < 32'(PALETTE_DEPTH));
  assign lim   = (32'(last_entry) >= 32'(PALETTE_DEPTH)) ? IDX_W'(PALETTE_DEPTH - 1)
                                                         : IDX_W'(last_entry);

  assign p_r = rd_data[CHAN_W-1:0];
  assign p_g = rd_data[2*CHAN_W-1:CHAN_W];
  assign p_b = rd_data[3*CHAN_W-1:2*CHAN_W];

  assign sts.scan_last = (cnt == lim);
  assign sts.pipe_busy = va || vb || vc;
  assign sts.out_free  = !m_tvalid || m_tready;

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem[IDX_W'(entry_index)] <= {blue, green, red};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[cnt];
  end

  // Query color and scan address.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_r <= red;
      q_g <= green;
      q_b <= blue;
      cnt <= '0;
    end else if (cmd.issue) begin
      cnt <= cnt + IDX_W'(1);
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    idx_a <= cnt;
    idx_b <= idx_a;
    idx_c <= idx_b;
    d_r   <= abs_diff(q_r, p_r);
    d_g   <= abs_diff(q_g, p_g);
    d_b   <= abs_diff(q_b, p_b);
    sum_c <= DIST_W'(d_r) + DIST_W'(d_g) + DIST_W'(d_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= cmd.issue;
      vb <= va;
      vc <= vb;
    end
  end

  // Strict compare keeps the lowest index on ties.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best <= DIST_BOUND;
      pick <= '0;
    end else if (vc && (sum_c < best)) begin
      best <= sum_c;
      pick <= idx_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      match_index <= ENTRY_W'(pick);
    end
  end

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a beat not yet taken");

  a_best_bounded: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.start) |-> (best <= DIST_BOUND))
    else $error("best distance above bound");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (best == DIST_BOUND && pick == '0))
    else $error("search tracker not initialized");
`endif

endmodule

`default_nettype wire

[rtl/core/nearest_palette_color_search.sv]
// Top level of the nearest palette color search: stream ports, register port, wiring.
// A write beat gives no result.
// A query beat occupies the block while it walks entries 0 to L, L = min(last_entry,
// depth - 1), one entry per cycle through the single read port of the palette memory,
// drains the read and distance stages, and loads the result once the output register
// is free; the result then appears on m_tdata.
// Reset (rst, synchronous) clears control state and sets last_entry to 255; palette
// contents are not cleared and must be written before they are searched.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_search
  import npcs_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,  // entry_index[7:0], red[23:8], green[39:24], blue[55:40]
  input  wire logic [0:0]  s_tuser,  // opcode[0]: 0 writes an entry, 1 queries
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // match_index[7:0]
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  op_t                 opcode;
  logic [ENTRY_W-1:0]  entry_index;
  logic [CHAN_W-1:0]   red, green, blue;
  logic [ENTRY_W-1:0]  last_entry;
  logic                reg_wr;

  // Unpack the input beat.
  assign opcode      = op_t'(s_tuser[0]);
  assign entry_index = s_tdata[7:0];
  assign red         = s_tdata[23:8];
  assign green       = s_tdata[39:24];
  assign blue        = s_tdata[55:40];

  // The register port never stalls. Only bit 2 of the address selects a word, so
  // the byte lanes of one word all map to the same register.
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_entry <= LAST_RESET;
    end else if (reg_wr && (paddr[2] == REG_LAST_ENTRY)) begin
      last_entry <= pwdata[ENTRY_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LAST_ENTRY) begin
      prdata = 32'(last_entry);
    end
  end

  // The controller only accepts beats while the scan pipeline is empty; the
  // output register lets a new beat in while an earlier result waits.
  npcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .opcode   (opcode),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  npcs_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_entry  (last_entry),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .match_index (m_tdata)
  );

endmodule

`default_nettype wire

[tb/palette_match_checker.sv]
// Watches the palette streams and register port, predicts every match index and compares.
`timescale 1ns / 1ps

module palette_match_checker
  import npcs_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,  // entry_index[7:0], red[23:8], green[39:24], blue[55:40]
  input  logic [0:0]  s_tuser,  // opcode[0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,  // match_index[7:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          pending_count,
  output int          lookup_count,
  output int          store_count
);

  localparam logic [2:0] LAST_ENTRY_ADDR = 3'(4 * REG_LAST_ENTRY);

  typedef struct {
    logic [ENTRY_W-1:0] match;
    logic [COLOR_W-1:0] color;
  } lookup_t;

  logic [CHAN_W-1:0]  pal_red   [PALETTE_DEPTH];
  logic [CHAN_W-1:0]  pal_green [PALETTE_DEPTH];
  logic [CHAN_W-1:0]  pal_blue  [PALETTE_DEPTH];
  logic [ENTRY_W-1:0] last_entry;
  lookup_t            expected_matches[$];
  int                 errors;
  int                 lookups;
  int                 stores;

  function automatic int unsigned chan_gap(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
    return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // Scans entries 0 through last_entry and keeps the first one strictly closer than
  // the best so far; the bound of three full channels means a pure opposite never wins.
  function automatic logic [ENTRY_W-1:0] nearest_entry(input logic [COLOR_W-1:0] color);
    int unsigned best;
    int unsigned gap_sum;
    int unsigned last;
    int unsigned pick;
    int unsigned i;
    best = DIST_BOUND;
    pick = 0;
    last = last_entry;
    if (last >= PALETTE_DEPTH) last = PALETTE_DEPTH - 1;
    for (i = 0; i <= last; i++) begin
      gap_sum = chan_gap(color[15:0], pal_red[i]) + chan_gap(color[31:16], pal_green[i]) +
                chan_gap(color[47:32], pal_blue[i]);
      if (gap_sum < best) begin
        best = gap_sum;
        pick = i;
      end
    end
    return ENTRY_W'(pick);
  endfunction

  always @(posedge clk) begin
    lookup_t head;
    lookup_t fresh;
    if (rst) begin
      expected_matches.delete();
      last_entry = LAST_RESET;
    end else begin
      // Results leave before the beat taken at the same edge can have produced one.
      if (m_tvalid && m_tready) begin
        if (expected_matches.size() == 0) begin
          $display("%0t: unexpected match_index beat, expected none, got %0d", $time, m_tdata);
          errors++;
        end else begin
          head = expected_matches.pop_front();
          if (m_tdata !== head.match) begin
            $display("%0t: match_index mismatch for color %h, expected %0d, got %0d",
                     $time, head.color, head.match, m_tdata);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (op_t'(s_tuser[0]) == OP_WRITE) begin
          if (s_tdata[7:0] < PALETTE_DEPTH) begin
            pal_red[s_tdata[7:0]]   = s_tdata[23:8];
            pal_green[s_tdata[7:0]] = s_tdata[39:24];
            pal_blue[s_tdata[7:0]]  = s_tdata[55:40];
          end
          stores++;
        end else begin
          fresh.color = s_tdata[55:8];
          fresh.match = nearest_entry(s_tdata[55:8]);
          expected_matches.push_back(fresh);
          lookups++;
        end
      end
      if (psel && penable && pready && paddr == LAST_ENTRY_ADDR) begin
        if (pwrite) begin
          last_entry = pwdata[ENTRY_W-1:0];
        end else if (prdata !== 32'(last_entry)) begin
          $display("%0t: last_entry read-back mismatch, expected %0d, got %0d",
                   $time, last_entry, prdata);
          errors++;
        end
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_matches.size();
    lookup_count   <= lookups;
    store_count    <= stores;
  end

endmodule

[tb/nearest_palette_color_search_tb.sv]
// Testbench top: clock, reset, palette and query stimulus, back-pressure and the verdict.
`timescale 1ns / 1ps

module nearest_palette_color_search_tb;
  import npcs_pkg::*;

  // The search walks one entry per cycle, so a full 256-entry lookup is the longest; the
  // long result hold-off also stalls the streams. The watchdog limit covers both several
  // times over.
  localparam int          WATCHDOG_LIMIT  = 4000;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          SETTLE_CYCLES   = 20;
  localparam int          DRAIN_CYCLES    = 300;
  localparam logic [2:0]  LAST_ENTRY_ADDR = 3'(4 * REG_LAST_ENTRY);

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata  = '0;  // entry_index[7:0], red[23:8], green[39:24], blue[55:40]
  logic [0:0]  s_tuser  = '0;  // opcode[0]: 0 writes an entry, 1 queries
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // match_index[7:0]
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int pending_count;
  int lookup_count;
  int store_count;

  // Idle percentages for the two sides of the stream, changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The stimulus keeps its own record of which entries hold a color, so that a lookup
  // never searches an entry that was never written. This record only steers stimulus.
  bit [COLOR_W-1:0] shadow_color[256];
  bit               written[256];
  logic [7:0]       cur_last = 8'd0;

  // A request for a long result hold-off travels as a counter that the receiver
  // process compares with its own copy.
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  nearest_palette_color_search i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  palette_match_checker i_match_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .lookup_count   (lookup_count),
    .store_count    (store_count)
  );

  // The receiver either serves a requested hold-off, counted here in cycles, or drops
  // tready at random with the current idle percentage.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The watchdog counts cycles in which no beat and no register access completes.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Colors are drawn so that many lookups land exactly on or next to a stored entry,
  // which is where ties and close calls live; the rest are extremes or fully random.
  function automatic bit [COLOR_W-1:0] random_color();
    int unsigned      mode;
    int               c;
    bit [COLOR_W-1:0] pick;
    mode = $urandom_range(99);
    pick = shadow_color[$urandom_range(cur_last)];
    if (mode < 30) return pick;
    if (mode < 45) begin
      return pick ^ {13'b0, 3'($urandom), 13'b0, 3'($urandom), 13'b0, 3'($urandom)};
    end
    if (mode < 60) begin
      for (c = 0; c < 3; c++) begin
        case ($urandom_range(2))
          0:       pick[16*c +: 16] = 16'h0000;
          1:       pick[16*c +: 16] = 16'hFFFF;
          default: pick[16*c +: 16] = 16'($urandom);
        endcase
      end
      return pick;
    end
    return COLOR_W'({$urandom, $urandom});
  endfunction

  // Offers one beat, at times with a random gap in front of it, and returns at the edge that
  // accepts it. The valid stays high into the next call when no gap follows.
  task automatic send_item(input op_t op, input logic [7:0] idx, input bit [COLOR_W-1:0] color);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {color, idx};
    do @(posedge clk); while (!s_tready);
    if (op == OP_WRITE) begin
      written[idx]      = 1'b1;
      shadow_color[idx] = color;
    end
  endtask

  // Stops offering beats until every lookup has returned, then lets the block settle.
  task automatic wait_idle(input int settle);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (settle) @(posedge clk);
  endtask

  // One register access: a setup phase, then the access phase until pready.
  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // The search length changes only with the block idle; the checker verifies the read-back.
  task automatic set_last_entry(input logic [7:0] value);
    wait_idle(SETTLE_CYCLES);
    reg_access(1'b1, LAST_ENTRY_ADDR, 32'(value));
    reg_access(1'b0, LAST_ENTRY_ADDR, 32'h0);
    cur_last = value;
  endtask

  // Writes every entry up to the given index that does not hold a color yet.
  task automatic ensure_written(input int upto);
    int i;
    for (i = 0; i <= upto; i++) begin
      if (!written[i]) send_item(OP_WRITE, 8'(i), random_color());
    end
  endtask

  // Mostly lookups; writes land mostly inside the searched range so the palette keeps
  // changing under the queries.
  task automatic random_items(input int count);
    logic [7:0] idx;
    repeat (count) begin
      if ($urandom_range(99) < 30) begin
        idx = ($urandom_range(99) < 70) ? 8'($urandom_range(cur_last)) : 8'($urandom_range(255));
        send_item(OP_WRITE, idx, random_color());
      end else begin
        send_item(OP_QUERY, 8'($urandom), random_color());
      end
    end
  endtask

  initial begin
    int level;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. With one entry searched, a color at the full distance from it
    // does not beat the bound and the answer stays 0.
    set_last_entry(8'd0);
    send_item(OP_WRITE, 8'd0, 48'h0000_0000_0000);
    send_item(OP_QUERY, 8'hFF, 48'hFFFF_FFFF_FFFF);
    send_item(OP_QUERY, 8'h00, 48'h0000_0000_0000);
    send_item(OP_WRITE, 8'd1, 48'hFFFF_FFFF_FFFF);
    send_item(OP_WRITE, 8'd2, {16'd300, 16'd200, 16'd100});
    send_item(OP_WRITE, 8'd3, {16'd300, 16'd200, 16'd100});
    send_item(OP_WRITE, 8'd255, {16'h8000, 16'h0001, 16'hFFFE});
    // Four entries: exact hits, a tie between entries 2 and 3 that the lower index
    // must win, and a close call between the two extreme entries.
    set_last_entry(8'd3);
    send_item(OP_QUERY, 8'h55, 48'hFFFF_FFFF_FFFF);
    send_item(OP_QUERY, 8'hAA, {16'd300, 16'd200, 16'd100});
    send_item(OP_QUERY, 8'h00, {16'd301, 16'd199, 16'd100});
    send_item(OP_QUERY, 8'hFF, {16'h8000, 16'h7FFF, 16'h8000});
    send_item(OP_QUERY, 8'h0F, {16'hFFFF, 16'h0000, 16'h0000});
    // Overwriting entry 1 with zero makes it tie with entry 0.
    send_item(OP_WRITE, 8'd1, 48'h0000_0000_0000);
    send_item(OP_QUERY, 8'hF0, 48'h0000_0000_0001);
    send_item(OP_WRITE, 8'd1, 48'hFFFF_FFFF_FFFF);
    send_item(OP_QUERY, 8'h3C, 48'hFFFF_0000_FFFF);

    // Sender idles often, the receiver more often.
    send_idle_pct = 37;
    recv_idle_pct = 61;
    set_last_entry(8'd1);
    random_items(100);
    level = $urandom_range(15, 2);
    ensure_written(level);
    set_last_entry(8'(level));
    random_items(150);

    // The other way round, with a longer palette.
    send_idle_pct = 61;
    recv_idle_pct = 37;
    level = $urandom_range(63, 16);
    ensure_written(level);
    set_last_entry(8'(level));
    random_items(200);

    // No random idling. The receiver first holds off for a long stretch while the
    // sender keeps offering beats, so the block fills and stalls its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= hold_req + 1;
    random_items(30);
    wait_idle(0);

    // Full palette, the longest search.
    ensure_written(255);
    set_last_entry(8'd255);
    random_items(20);
    set_last_entry(8'd0);
    random_items(40);
    level = $urandom_range(31, 4);
    set_last_entry(8'(level));
    random_items(100);

    wait_idle(DRAIN_CYCLES);
    $display("Checked %0d palette lookups against %0d entry writes", lookup_count, store_count);
    $display("over search lengths from 1 to 256 entries, with stalls on both streams.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
